/* design/tcst_pkg.sv */
// Shared types for the call stack tracker.
package tcst_pkg;

	// Stack operation for one trace request; push and pop are never both set.
	typedef struct packed {
		logic push;
		logic pop;
	} stack_cmd_t;

endpackage

/* design/tcst_stack.sv */
// Bounded call stack: register window of the newest entries over a circular memory.
module tcst_stack #(
	parameter int VIEW_DEPTH   = 4,
	parameter int STACK_DEPTH  = 64,
	parameter int FUNC_ID_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  tcst_pkg::stack_cmd_t                     cmd,
	input  logic [FUNC_ID_BITS-1:0]                  push_id,
	output logic [VIEW_DEPTH-1:0][FUNC_ID_BITS-1:0]  view
);
	import tcst_pkg::*;

	localparam int WIN_CAP   = (STACK_DEPTH < VIEW_DEPTH) ? STACK_DEPTH : VIEW_DEPTH;
	localparam bit HAS_MEM   = (STACK_DEPTH > VIEW_DEPTH);
	localparam int MEM_DEPTH = HAS_MEM ? (STACK_DEPTH - VIEW_DEPTH) : 1;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int MEM_CW    = $clog2(MEM_DEPTH + 1);
	localparam int WIN_CW    = $clog2(WIN_CAP + 1);

	logic [FUNC_ID_BITS-1:0] win_q [VIEW_DEPTH];
	logic [FUNC_ID_BITS-1:0] win_d [VIEW_DEPTH];
	logic [WIN_CW-1:0]       win_cnt_q, win_cnt_d;
	logic [MEM_CW-1:0]       mem_cnt_q, mem_cnt_d;
	logic [MEM_AW-1:0]       wp_q, wp_d, wp_inc, wp_dec, rd_addr;
	logic [FUNC_ID_BITS-1:0] mem [MEM_DEPTH];
	logic [FUNC_ID_BITS-1:0] mem_rd_q, byp_data_q, top_val, spill;
	logic                    byp_q;
	logic                    full_win, mem_has, do_pop, mem_wr;

	assign full_win = (win_cnt_q == WIN_CW'(WIN_CAP));
	assign mem_has  = (mem_cnt_q != '0);
	// The memory read is registered; the entry spilled in the last cycle is bypassed.
	assign top_val  = byp_q ? byp_data_q : mem_rd_q;
	assign spill    = win_q[WIN_CAP-1];
	assign do_pop   = cmd.pop && (win_cnt_q != '0);
	assign mem_wr   = cmd.push && full_win && HAS_MEM;

	assign wp_inc = (wp_q == MEM_AW'(MEM_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign wp_dec = (wp_q == '0) ? MEM_AW'(MEM_DEPTH - 1) : wp_q - 1'b1;

	always_comb begin
		if (mem_wr) begin
			wp_d = wp_inc;
		end else if (do_pop && mem_has) begin
			wp_d = wp_dec;
		end else begin
			wp_d = wp_q;
		end
	end

	// Always read the entry just below the next write slot, the top of the memory part.
	assign rd_addr = (wp_d == '0) ? MEM_AW'(MEM_DEPTH - 1) : wp_d - 1'b1;

	always_comb begin
		for (int k = 0; k < VIEW_DEPTH; k++) begin
			win_d[k] = win_q[k];
		end
		win_cnt_d = win_cnt_q;
		mem_cnt_d = mem_cnt_q;
		if (cmd.push) begin
			win_d[0] = push_id;
			for (int k = 1; k < VIEW_DEPTH; k++) begin
				win_d[k] = (k < WIN_CAP) ? win_q[k-1] : '0;
			end
			if (!full_win) begin
				win_cnt_d = win_cnt_q + 1'b1;
			end else if (HAS_MEM && (mem_cnt_q != MEM_CW'(MEM_DEPTH))) begin
				mem_cnt_d = mem_cnt_q + 1'b1;
			end
		end else if (do_pop) begin
			for (int k = 0; k < VIEW_DEPTH - 1; k++) begin
				win_d[k] = win_q[k+1];
			end
			win_d[VIEW_DEPTH-1] = '0;
			win_d[WIN_CAP-1]    = mem_has ? top_val : '0;
			if (mem_has) begin
				mem_cnt_d = mem_cnt_q - 1'b1;
			end else begin
				win_cnt_d = win_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VIEW_DEPTH; k++) begin
				win_q[k] <= '0;
			end
			win_cnt_q <= '0;
			mem_cnt_q <= '0;
			wp_q      <= '0;
			byp_q     <= 1'b0;
		end else begin
			for (int k = 0; k < VIEW_DEPTH; k++) begin
				win_q[k] <= win_d[k];
			end
			win_cnt_q <= win_cnt_d;
			mem_cnt_q <= mem_cnt_d;
			wp_q      <= wp_d;
			byp_q     <= mem_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[wp_q]  <= spill;
			byp_data_q <= spill;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_comb begin
		for (int k = 0; k < VIEW_DEPTH; k++) begin
			view[k] = win_q[k];
		end
	end

endmodule

/* design/trace_call_stack_tracker_core.sv */
// Top level of the call stack tracker: request handshakes, transition detection, result register.
//
// Channel  Dir  Payload                                   Meaning
// s_*      in   tdata: func_id; tuser: is_call, is_ret    one retired-instruction trace request
// m_*      out  tdata: top0..top(N-1); tuser: ctx_valid   stack view after that request
//
// Each accepted request yields exactly one result. The block takes one request per cycle while
// the result side is not stalled: each request is captured in an input register, then the
// transition check and the stack push or pop land in the stack window, which is also the
// result register. A pop that reaches below the window refills from a memory whose registered
// read port is always kept pointed at the next entry, so pops can follow each other in
// consecutive cycles. Reset (arst_n, asynchronous, active low) empties the stack and clears
// the previous-item history; no clearing pass is needed. While a result is stalled, the input
// register still takes one more request, after which s_tready follows m_tready.
module trace_call_stack_tracker_core #(
	parameter int VIEW_DEPTH   = 4,
	parameter int STACK_DEPTH  = 64,
	parameter int FUNC_ID_BITS = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               s_tvalid,
	output logic                                               s_tready,
	input  logic [((FUNC_ID_BITS+7)/8)*8-1:0]                  s_tdata,  // func_id
	input  logic [1:0]                                         s_tuser,  // is_call, is_ret
	output logic                                               m_tvalid,
	input  logic                                               m_tready,
	output logic [((VIEW_DEPTH*FUNC_ID_BITS+7)/8)*8-1:0]       m_tdata,  // top0, top1, ...
	output logic                                               m_tuser   // ctx_valid
);
	import tcst_pkg::*;

	localparam int OUT_DATA_W = ((VIEW_DEPTH * FUNC_ID_BITS + 7) / 8) * 8;

	// Input register.
	logic                    valid_s1;
	logic [FUNC_ID_BITS-1:0] func_s1;
	logic                    call_s1, ret_s1;

	// History of the previous request.
	logic [FUNC_ID_BITS-1:0] last_func_q;
	logic                    last_call_q, last_ret_q;

	logic                    m_tvalid_q, ctx_valid_q;
	logic                    advance, func_switch;
	stack_cmd_t              cmd;
	logic [VIEW_DEPTH-1:0][FUNC_ID_BITS-1:0] view;

	// The request in the input register moves on when the result register is free or drains.
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// A change between two known functions is a call edge, a return edge or neither, depending on
	// what the previous request held. A call wins when both were flagged.
	assign func_switch = (last_func_q != '0) && (func_s1 != '0) && (last_func_q != func_s1);
	assign cmd.push    = advance && func_switch && last_call_q;
	assign cmd.pop     = advance && func_switch && !last_call_q && last_ret_q;

	tcst_stack #(
		.VIEW_DEPTH  (VIEW_DEPTH),
		.STACK_DEPTH (STACK_DEPTH),
		.FUNC_ID_BITS(FUNC_ID_BITS)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.push_id(func_s1),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_func_q <= '0;
			last_call_q <= 1'b0;
			last_ret_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				last_func_q <= func_s1;
				last_call_q <= call_s1;
				last_ret_q  <= ret_s1;
				m_tvalid_q  <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tdata[FUNC_ID_BITS-1:0];
			call_s1 <= s_tuser[0];
			ret_s1  <= s_tuser[1];
		end
		if (advance) begin
			ctx_valid_q <= (func_s1 != '0);
		end
	end

	// The stack window doubles as the result data register.
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = ctx_valid_q;
	assign m_tdata  = OUT_DATA_W'(view);

	// A stalled result is never overwritten by the next request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !advance)
		else $error("result overwritten while stalled");

	// A call edge puts the new function on top of the view.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (m_tdata[FUNC_ID_BITS-1:0] == $past(func_s1)))
		else $error("pushed function not on top of stack");

	// A request with no known function leaves the stack view untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (func_s1 == '0)) |=> (m_tdata == $past(m_tdata)))
		else $error("stack changed on unknown function");

	// With the result register empty the block always takes a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid_q |-> s_tready)
		else $error("input stalled with result register empty");

endmodule

/* tb/sv/trace_call_stack_tracker_core_tb.sv */
// Self-checking testbench for the call stack tracker: directed and random trace requests.
`timescale 1ns / 1ps

module trace_call_stack_tracker_core_tb;
	import tcst_pkg::*;

	localparam int VIEW_DEPTH   = 4;
	localparam int STACK_DEPTH  = 64;
	localparam int FID_W        = 16;
	localparam int RANDOM_ITEMS = 1530;
	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_PRINTS   = 50;

	// Stack view that one trace request should produce.
	typedef struct {
		logic             ctx_valid;
		logic [FID_W-1:0] tops [VIEW_DEPTH];
	} stack_view_t;

	// Flavors of random trace segments.
	typedef enum int {
		MIX_CALLS,
		MIX_RETURNS,
		MIX_BALANCED,
		MIX_NOISE
	} trace_mix_t;

	// Tracks the call stack the block should hold and the views it still owes.
	class call_stack_scoreboard;
		logic [FID_W-1:0] frames [$];	// index 0 is the oldest frame
		logic [FID_W-1:0] prev_fid;
		logic             last_call;
		logic             last_ret;
		stack_view_t      owed_views [$];
		int unsigned      errors;

		function new();
			prev_fid  = '0;
			last_call = 1'b0;
			last_ret  = 1'b0;
			errors    = 0;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return owed_views.size();
		endfunction

		// Applies one accepted request and queues the view it should produce.
		function void note_request(logic [FID_W-1:0] fid, logic call, logic ret);
			stack_cmd_t  cmd;
			stack_view_t view;
			int          depth;
			cmd = '0;
			// Only a move between two known, different functions touches the stack.
			if (prev_fid != '0 && fid != '0 && prev_fid != fid) begin
				if (last_call)
					cmd.push = 1'b1;
				else if (last_ret)
					cmd.pop = 1'b1;
			end
			if (cmd.push) begin
				// A full stack loses its oldest frame to make room.
				if (frames.size() == STACK_DEPTH)
					void'(frames.pop_front());
				frames.insert(frames.size(), fid);
			end else if (cmd.pop && frames.size() != 0) begin
				frames.delete(frames.size() - 1);
			end
			prev_fid  = fid;
			last_call = call;
			last_ret  = ret;
			view.ctx_valid = (fid != '0);
			depth = frames.size();
			for (int k = 0; k < VIEW_DEPTH; k++)
				view.tops[k] = (k < depth) ? frames[depth-1-k] : '0;
			owed_views.insert(owed_views.size(), view);
		endfunction

		// Compares one delivered result with the oldest owed view.
		task check_view(logic valid, logic [VIEW_DEPTH*FID_W-1:0] data);
			stack_view_t want;
			logic [FID_W-1:0] got;
			if (owed_views.size() == 0) begin
				report("result arrived with no request outstanding");
				return;
			end
			want = owed_views.pop_front();
			if (valid !== want.ctx_valid)
				report($sformatf("ctx_valid got %b want %b", valid, want.ctx_valid));
			for (int k = 0; k < VIEW_DEPTH; k++) begin
				got = data[k*FID_W +: FID_W];
				if (got !== want.tops[k])
					report($sformatf("top%0d got %h want %h", k, got, want.tops[k]));
			end
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [FID_W-1:0]               s_tdata = '0;	// func_id
	logic [1:0]                     s_tuser = '0;	// is_call, is_ret
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [VIEW_DEPTH*FID_W-1:0]    m_tdata;	// top0, top1, top2, top3
	logic                           m_tuser;	// ctx_valid

	// Receiver control: calm turns off random stalls, hold_req asks for one long hold-off.
	logic                           calm = 1'b0;
	logic                           hold_req = 1'b0;
	logic                           hold_done = 1'b0;
	int unsigned                    hold_left = 0;
	int unsigned                    cycles = 0;

	call_stack_scoreboard sb = new();

	trace_call_stack_tracker_core #(
		.VIEW_DEPTH  (VIEW_DEPTH),
		.STACK_DEPTH (STACK_DEPTH),
		.FUNC_ID_BITS(FID_W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off that lets the block back up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= 15);
		end
	end

	// Every accepted result is checked against the oldest owed view.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_view(m_tuser, m_tdata);
	end

	// Offers one request, with an occasional idle cycle first, and waits for its handshake.
	// Called at a rising edge; leaves tvalid high so back-to-back requests need no toggle.
	task automatic send_request(logic [FID_W-1:0] fid, logic call, logic ret);
		if (!calm && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= fid;
		s_tuser  <= {ret, call};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(fid, call, ret);
	endtask

	// Stops offering until every owed result has been delivered.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [FID_W-1:0] fresh_fid(logic [FID_W-1:0] prev);
		logic [FID_W-1:0] f;
		do
			f = FID_W'($urandom_range(1, (1 << FID_W) - 1));
		while (f == prev);
		return f;
	endfunction

	initial begin
		trace_mix_t       mix;
		int               seg_len;
		int               sent;
		logic [FID_W-1:0] fid;
		logic [FID_W-1:0] prev;
		logic             call;
		logic             ret;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unknown functions, id extremes, call and return together,
		// pop on an empty stack, repeats of the same function, a view deeper than four.
		send_request(16'h0000, 1'b0, 1'b0);
		send_request(16'hFFFF, 1'b1, 1'b0);	// known after unknown: no push
		send_request(16'h0001, 1'b0, 1'b0);	// push
		send_request(16'h0001, 1'b1, 1'b1);	// same function: untouched
		send_request(16'hFFFF, 1'b0, 1'b1);	// call and return both set: push wins
		send_request(16'h8000, 1'b0, 1'b0);	// pop
		send_request(16'h7FFF, 1'b0, 1'b1);	// previous had no flag
		send_request(16'h0001, 1'b0, 1'b1);	// pop to empty
		send_request(16'h1234, 1'b0, 1'b0);	// pop on empty is ignored
		send_request(16'h0000, 1'b1, 1'b0);
		send_request(16'h5555, 1'b1, 1'b0);
		send_request(16'h0000, 1'b0, 1'b0);	// unknown after a call: untouched
		send_request(16'hAAAA, 1'b1, 1'b0);
		send_request(16'hAAAA, 1'b1, 1'b0);
		send_request(16'h0F0F, 1'b1, 1'b0);
		send_request(16'hF0F0, 1'b1, 1'b0);
		send_request(16'h00FF, 1'b1, 1'b0);
		send_request(16'hFF00, 1'b1, 1'b0);
		send_request(16'h3C3C, 1'b0, 1'b1);	// five deep, only four visible
		send_request(16'hC3C3, 1'b0, 1'b1);
		send_request(16'h9999, 1'b0, 1'b0);
		send_request(16'h0000, 1'b0, 1'b1);	// ctx_valid low, tops still shown
		drain_results();

		// Random: segments of one flavor each; the first is long and call-heavy so
		// the stack overflows and starts dropping its oldest frames.
		sent = 0;
		prev = 16'h0000;
		while (sent < RANDOM_ITEMS) begin
			mix = (sent == 0) ? MIX_CALLS : trace_mix_t'($urandom_range(0, 3));
			seg_len = (sent == 0) ? 90 : $urandom_range(10, 80);
			for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
				case (mix)
					MIX_CALLS: begin
						fid  = fresh_fid(prev);
						call = ($urandom_range(0, 99) < 95);
						ret  = ($urandom_range(0, 99) < 10);
					end
					MIX_RETURNS: begin
						fid  = fresh_fid(prev);
						call = ($urandom_range(0, 99) < 5);
						ret  = ($urandom_range(0, 99) < 90);
					end
					MIX_BALANCED: begin
						fid  = ($urandom_range(0, 99) < 30 && prev != '0) ? prev
							: fresh_fid(prev);
						call = ($urandom_range(0, 99) < 45);
						ret  = ($urandom_range(0, 99) < 45);
					end
					default: begin
						fid  = ($urandom_range(0, 99) < 30) ? '0
							: FID_W'($urandom_range(0, (1 << FID_W) - 1));
						call = 1'($urandom_range(0, 1));
						ret  = 1'($urandom_range(0, 1));
					end
				endcase
				if (sent == 300)
					hold_req <= 1'b1;
				if (sent == 1200)
					drain_results();
				calm <= (sent >= 700 && sent < 1000);
				send_request(fid, call, ret);
				prev = fid;
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		calm <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("requests left without a result");
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* trace_call_stack_tracker_core.f */
design/tcst_pkg.sv
design/tcst_stack.sv
design/trace_call_stack_tracker_core.sv
tb/sv/trace_call_stack_tracker_core_tb.sv
